// File: sv/tsbm_pkg.sv
package tsbm_pkg;

	localparam int ACT_W = 3;
	localparam int BYTE_W = 8;
	localparam int CMD_W = 3;
	localparam int CFG_IDX_W = 1;
	localparam int QDEPTH = 2;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	localparam logic [ACT_W-1:0] ACT_TICK = 3'd0;
	localparam logic [ACT_W-1:0] ACT_RESET = 3'd1;
	localparam logic [ACT_W-1:0] ACT_START = 3'd2;
	localparam logic [ACT_W-1:0] ACT_WRITE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ = 3'd4;

	localparam logic [CMD_W-1:0] CMD_NONE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RESET = 3'd1;
	localparam logic [CMD_W-1:0] CMD_START = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SHORT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG = 1'd1;

	localparam logic [BYTE_W-1:0] SHORT_RST = 8'd5;
	localparam logic [BYTE_W-1:0] LONG_RST = 8'd15;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [BYTE_W-1:0] tx_byte;
		logic end_read;
		logic data_line;
	} item_t;

endpackage

// File: sv/tsbm_tick_if.sv
interface tsbm_tick_if;
	import tsbm_pkg::*;

	logic valid;
	logic ready;
	logic [ACT_W-1:0] action;
	logic [BYTE_W-1:0] tx_byte;
	logic end_read;
	logic data_line;

	modport source (output valid, output action, output tx_byte, output end_read,
		output data_line, input ready);
	modport sink (input valid, input action, input tx_byte, input end_read,
		input data_line, output ready);
endinterface

// File: sv/tsbm_status_if.sv
interface tsbm_status_if;
	import tsbm_pkg::*;

	logic valid;
	logic ready;
	logic sck;
	logic data_drive;
	logic data_level;
	logic busy_res;
	logic op_done;
	logic [BYTE_W-1:0] rx_byte;
	logic ack_error;
	logic conversion_ready;

	modport source (output valid, output sck, output data_drive, output data_level,
		output busy_res, output op_done, output rx_byte, output ack_error,
		output conversion_ready, input ready);
	modport sink (input valid, input sck, input data_drive, input data_level,
		input busy_res, input op_done, input rx_byte, input ack_error,
		input conversion_ready, output ready);
endinterface

// File: sv/tsbm_front.sv
module tsbm_front (
	input logic clk,
	input logic arst_n,
	tsbm_tick_if.sink tick,
	output logic push_valid,
	input logic push_ready,
	output tsbm_pkg::item_t push_item
);
	import tsbm_pkg::*;

	logic valid_s1;
	item_t item_s1;
	logic [CMD_W-1:0] cmd;

	always_comb begin
		case (tick.action)
			ACT_RESET: cmd = CMD_RESET;
			ACT_START: cmd = CMD_START;
			ACT_WRITE: cmd = CMD_WRITE;
			ACT_READ: cmd = CMD_READ;
			default: cmd = CMD_NONE;
		endcase
	end

	assign tick.ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			item_s1.cmd <= cmd;
			item_s1.tx_byte <= tick.tx_byte;
			item_s1.end_read <= tick.end_read;
			item_s1.data_line <= tick.data_line;
		end
	end

	assign push_valid = valid_s1;
	assign push_item = item_s1;
endmodule

// File: sv/tsbm_queue.sv
module tsbm_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input tsbm_pkg::item_t push_item,
	output logic pop_valid,
	input logic pop_ready,
	output tsbm_pkg::item_t pop_item
);
	import tsbm_pkg::*;

	item_t entry_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = count_q != QCW'(QDEPTH);
	assign pop_valid = count_q != '0;
	assign pop_item = entry_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH))
		else $error("Queue holds more entries than its depth.");
`endif
endmodule

// File: sv/tsbm_back.sv
module tsbm_back (
	input logic clk,
	input logic arst_n,
	input logic [tsbm_pkg::BYTE_W-1:0] short_ticks,
	input logic [tsbm_pkg::BYTE_W-1:0] long_ticks,
	input logic pop_valid,
	output logic pop_ready,
	input tsbm_pkg::item_t pop_item,
	tsbm_status_if.source status
);
	import tsbm_pkg::*;

	localparam int PH_W = 5;
	localparam int CNT_W = 4;
	localparam logic [PH_W-1:0] P_IDLE = 5'd0;
	localparam logic [PH_W-1:0] P_WSET = 5'd1;
	localparam logic [PH_W-1:0] P_WHIGH = 5'd2;
	localparam logic [PH_W-1:0] P_WLOW = 5'd3;
	localparam logic [PH_W-1:0] P_WACKH = 5'd4;
	localparam logic [PH_W-1:0] P_WACKS = 5'd5;
	localparam logic [PH_W-1:0] P_RREL = 5'd6;
	localparam logic [PH_W-1:0] P_RHIGH = 5'd7;
	localparam logic [PH_W-1:0] P_RLOW = 5'd8;
	localparam logic [PH_W-1:0] P_RACK = 5'd9;
	localparam logic [PH_W-1:0] P_RTAIL = 5'd10;
	localparam logic [PH_W-1:0] P_CPRE = 5'd11;
	localparam logic [PH_W-1:0] P_CHIGH = 5'd12;
	localparam logic [PH_W-1:0] P_CLOW = 5'd13;
	localparam logic [PH_W-1:0] P_S1 = 5'd14;
	localparam logic [PH_W-1:0] P_S2 = 5'd15;
	localparam logic [PH_W-1:0] P_S3 = 5'd16;
	localparam logic [PH_W-1:0] P_S4 = 5'd17;
	localparam logic [PH_W-1:0] P_S5 = 5'd18;
	localparam logic [PH_W-1:0] P_S6 = 5'd19;
	localparam logic [PH_W-1:0] P_S7 = 5'd20;
	localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;
	localparam logic [CNT_W-1:0] RESET_CLOCKS = 4'd9;

	typedef struct packed {
		logic sck;
		logic drv;
		logic lvl;
		logic is_long;
	} pins_t;

	function automatic pins_t enter_pins(input logic [PH_W-1:0] p,
		input logic [BYTE_W-1:0] sh, input logic lvl, input logic rend);
		pins_t r;
		case (p)
			P_WSET: r = '{1'b0, 1'b1, sh[BYTE_W-1], 1'b0};
			P_WHIGH: r = '{1'b1, 1'b1, sh[BYTE_W-1], 1'b1};
			P_WLOW: r = '{1'b0, 1'b1, lvl, 1'b0};
			P_WACKH: r = '{1'b1, 1'b0, 1'b0, 1'b1};
			P_WACKS: r = '{1'b1, 1'b0, 1'b0, 1'b0};
			P_RREL: r = '{1'b0, 1'b0, 1'b0, 1'b0};
			P_RHIGH: r = '{1'b1, 1'b0, 1'b0, 1'b0};
			P_RLOW: r = '{1'b0, 1'b0, 1'b0, 1'b0};
			P_RACK: r = '{1'b1, 1'b1, rend, 1'b1};
			P_RTAIL: r = '{1'b0, 1'b1, rend, 1'b0};
			P_CPRE: r = '{1'b0, 1'b1, 1'b1, 1'b0};
			P_CHIGH: r = '{1'b1, 1'b1, 1'b1, 1'b1};
			P_CLOW: r = '{1'b0, 1'b1, 1'b1, 1'b1};
			P_S1: r = '{1'b0, 1'b1, 1'b1, 1'b0};
			P_S2: r = '{1'b1, 1'b1, 1'b1, 1'b0};
			P_S3: r = '{1'b1, 1'b1, 1'b0, 1'b0};
			P_S4: r = '{1'b0, 1'b1, 1'b0, 1'b1};
			P_S5: r = '{1'b1, 1'b1, 1'b0, 1'b0};
			P_S6: r = '{1'b1, 1'b1, 1'b1, 1'b0};
			P_S7: r = '{1'b0, 1'b1, 1'b1, 1'b0};
			default: r = '{1'b0, 1'b0, 1'b0, 1'b0};
		endcase
		return r;
	endfunction

	logic [PH_W-1:0] phase_q, phase_n;
	logic [CNT_W-1:0] bit_q, bit_n;
	logic [BYTE_W-1:0] dly_q, dly_n;
	logic [BYTE_W-1:0] sh_q, sh_n;
	logic [BYTE_W-1:0] rx_q, rx_n;
	logic ack_q, ack_n;
	logic rend_q, rend_n;
	logic sck_q, sck_n;
	logic drv_q, drv_n;
	logic lvl_q, lvl_n;
	logic done;
	logic ent;
	logic fin;
	logic [PH_W-1:0] ent_p;
	logic [BYTE_W-1:0] len;
	pins_t pins;
	logic out_valid_q;
	logic pop;

	assign pop_ready = !out_valid_q || status.ready;
	assign pop = pop_valid && pop_ready;

	always_comb begin
		phase_n = phase_q;
		bit_n = bit_q;
		dly_n = dly_q;
		sh_n = sh_q;
		rx_n = rx_q;
		ack_n = ack_q;
		rend_n = rend_q;
		sck_n = sck_q;
		drv_n = drv_q;
		lvl_n = lvl_q;
		done = 1'b0;
		ent = 1'b0;
		fin = 1'b0;
		ent_p = P_IDLE;
		if (phase_q == P_IDLE) begin
			if (pop_item.cmd != CMD_NONE) begin
				bit_n = '0;
				ent = 1'b1;
				case (pop_item.cmd)
					CMD_RESET: ent_p = P_CPRE;
					CMD_START: ent_p = P_S1;
					CMD_WRITE: begin
						sh_n = pop_item.tx_byte;
						ent_p = P_WSET;
					end
					default: begin
						sh_n = '0;
						rend_n = pop_item.end_read;
						ent_p = P_RREL;
					end
				endcase
			end
		end else if (dly_q != '0) begin
			dly_n = dly_q - BYTE_W'(1);
		end else begin
			ent = 1'b1;
			case (phase_q)
				P_WSET: ent_p = P_WHIGH;
				P_WHIGH: begin
					sh_n = {sh_q[BYTE_W-2:0], 1'b0};
					ent_p = P_WLOW;
				end
				P_WLOW: begin
					bit_n = bit_q + CNT_W'(1);
					ent_p = (bit_n < BITS_PER_BYTE) ? P_WSET : P_WACKH;
				end
				P_WACKH: begin
					ack_n = pop_item.data_line;
					ent_p = P_WACKS;
				end
				P_RREL: ent_p = P_RHIGH;
				P_RHIGH: begin
					sh_n = {sh_q[BYTE_W-2:0], pop_item.data_line};
					ent_p = P_RLOW;
				end
				P_RLOW: begin
					bit_n = bit_q + CNT_W'(1);
					ent_p = (bit_n < BITS_PER_BYTE) ? P_RHIGH : P_RACK;
				end
				P_RACK: ent_p = P_RTAIL;
				P_RTAIL: begin
					rx_n = sh_q;
					ent = 1'b0;
					fin = 1'b1;
				end
				P_CPRE: ent_p = P_CHIGH;
				P_CHIGH: ent_p = P_CLOW;
				P_CLOW: begin
					bit_n = bit_q + CNT_W'(1);
					ent_p = (bit_n < RESET_CLOCKS) ? P_CHIGH : P_S1;
				end
				P_S1: ent_p = P_S2;
				P_S2: ent_p = P_S3;
				P_S3: ent_p = P_S4;
				P_S4: ent_p = P_S5;
				P_S5: ent_p = P_S6;
				P_S6: ent_p = P_S7;
				default: begin
					ent = 1'b0;
					fin = 1'b1;
				end
			endcase
		end
		pins = enter_pins(ent_p, sh_n, lvl_q, rend_n);
		len = pins.is_long ? long_ticks : short_ticks;
		if (ent) begin
			phase_n = ent_p;
			sck_n = pins.sck;
			drv_n = pins.drv;
			lvl_n = pins.drv & pins.lvl;
			dly_n = (len == '0) ? '0 : len - BYTE_W'(1);
		end
		if (fin) begin
			phase_n = P_IDLE;
			dly_n = '0;
			sck_n = 1'b0;
			drv_n = 1'b0;
			lvl_n = 1'b0;
			done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			bit_q <= '0;
			dly_q <= '0;
			sh_q <= '0;
			rx_q <= '0;
			ack_q <= 1'b0;
			rend_q <= 1'b0;
			sck_q <= 1'b0;
			drv_q <= 1'b0;
			lvl_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_n;
				bit_q <= bit_n;
				dly_q <= dly_n;
				sh_q <= sh_n;
				rx_q <= rx_n;
				ack_q <= ack_n;
				rend_q <= rend_n;
				sck_q <= sck_n;
				drv_q <= drv_n;
				lvl_q <= lvl_n;
				out_valid_q <= 1'b1;
			end else if (status.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status.sck <= sck_n;
			status.data_drive <= drv_n;
			status.data_level <= lvl_n;
			status.busy_res <= phase_n != P_IDLE;
			status.op_done <= done;
			status.rx_byte <= rx_n;
			status.ack_error <= ack_n;
			status.conversion_ready <= !pop_item.data_line;
		end
	end

	assign status.valid = out_valid_q;

`ifndef SYNTHESIS
	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == P_IDLE) |-> (!sck_q && !drv_q && dly_q == '0))
		else $error("Pins or delay left active while the sequencer is idle.");
	a_level_released: assert property (@(posedge clk) disable iff (!arst_n)
		!drv_q |-> !lvl_q)
		else $error("Data level is set while the data pin is released.");
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(status.valid && status.op_done) |-> !status.busy_res)
		else $error("Completion reported while a command is still running.");
`endif
endmodule

// File: sv/two_wire_sensor_bus_master.sv
// One input transfer is one bus tick; the block takes a tick every cycle unless the status stalls.
// A tick's status passes the classify stage register, the queue and the status register before it is valid.
// Throughput: one tick per cycle unless the status output stalls, one sequencer step per tick.
// Reset is asynchronous and active low; it idles the sequencer, releases the pins
// and loads the phase lengths with five short and fifteen long ticks.
module two_wire_sensor_bus_master (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [tsbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tsbm_pkg::BYTE_W-1:0] cfg_wdata,
	tsbm_tick_if.sink tick,
	tsbm_status_if.source status
);
	import tsbm_pkg::*;

	logic [BYTE_W-1:0] short_ticks_q;
	logic [BYTE_W-1:0] long_ticks_q;
	logic push_valid;
	logic push_ready;
	item_t push_item;
	logic pop_valid;
	logic pop_ready;
	item_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_ticks_q <= SHORT_RST;
			long_ticks_q <= LONG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHORT: short_ticks_q <= cfg_wdata;
				REG_LONG: long_ticks_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	tsbm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item)
	);

	tsbm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item)
	);

	tsbm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.short_ticks(short_ticks_q),
		.long_ticks(long_ticks_q),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item),
		.status(status)
	);
endmodule

// File: tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tsbm_pkg::*;

	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int DRAIN_CYCLES = 4;
	localparam int ITEM_TARGET = 700;
	localparam logic [ACT_W-1:0] ACT_LAST_CODE = 3'd7;

	typedef enum logic [4:0] {
		PH_IDLE, PH_WSET, PH_WHIGH, PH_WLOW, PH_WACKH, PH_WACKS,
		PH_RREL, PH_RHIGH, PH_RLOW, PH_RACK, PH_RTAIL,
		PH_CPRE, PH_CHIGH, PH_CLOW,
		PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_ST5, PH_ST6, PH_ST7
	} bus_phase_t;

	typedef struct packed {
		logic sck;
		logic data_drive;
		logic data_level;
		logic busy_res;
		logic op_done;
		logic [BYTE_W-1:0] rx_byte;
		logic ack_error;
		logic conversion_ready;
	} status_t;

	// Tracks the bus sequencer tick by tick and holds the pin status each tick should show.
	class bus_timeline;
		logic [BYTE_W-1:0] short_len;
		logic [BYTE_W-1:0] long_len;
		bus_phase_t phase;
		logic [3:0] bit_cnt;
		logic [BYTE_W-1:0] delay;
		logic [BYTE_W-1:0] shreg;
		logic ack;
		logic pin_sck;
		logic pin_drive;
		logic pin_level;
		logic [BYTE_W-1:0] last_rx;
		logic end_level;
		status_t due_status[$];
		int errors;

		function new();
			short_len = SHORT_RST;
			long_len = LONG_RST;
			phase = PH_IDLE;
			bit_cnt = '0;
			delay = '0;
			shreg = '0;
			ack = 1'b0;
			pin_sck = 1'b0;
			pin_drive = 1'b0;
			pin_level = 1'b0;
			last_rx = '0;
			end_level = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
			if (idx == REG_SHORT) begin
				short_len = val;
			end else begin
				long_len = val;
			end
		endfunction

		function void pins(logic s, logic d, logic l);
			pin_sck = s;
			pin_drive = d;
			pin_level = d ? l : 1'b0;
		endfunction

		function void enter(bus_phase_t p);
			logic is_long;
			logic [BYTE_W-1:0] len;
			is_long = 1'b0;
			phase = p;
			case (p)
				PH_WSET: pins(1'b0, 1'b1, shreg[7]);
				PH_WHIGH: begin
					pins(1'b1, 1'b1, shreg[7]);
					is_long = 1'b1;
				end
				PH_WLOW: pins(1'b0, 1'b1, pin_level);
				PH_WACKH: begin
					pins(1'b1, 1'b0, 1'b0);
					is_long = 1'b1;
				end
				PH_WACKS: pins(1'b1, 1'b0, 1'b0);
				PH_RREL: pins(1'b0, 1'b0, 1'b0);
				PH_RHIGH: pins(1'b1, 1'b0, 1'b0);
				PH_RLOW: pins(1'b0, 1'b0, 1'b0);
				PH_RACK: begin
					pins(1'b1, 1'b1, end_level);
					is_long = 1'b1;
				end
				PH_RTAIL: pins(1'b0, 1'b1, end_level);
				PH_CPRE: pins(1'b0, 1'b1, 1'b1);
				PH_CHIGH: begin
					pins(1'b1, 1'b1, 1'b1);
					is_long = 1'b1;
				end
				PH_CLOW: begin
					pins(1'b0, 1'b1, 1'b1);
					is_long = 1'b1;
				end
				PH_ST1: pins(1'b0, 1'b1, 1'b1);
				PH_ST2: pins(1'b1, 1'b1, 1'b1);
				PH_ST3: pins(1'b1, 1'b1, 1'b0);
				PH_ST4: begin
					pins(1'b0, 1'b1, 1'b0);
					is_long = 1'b1;
				end
				PH_ST5: pins(1'b1, 1'b1, 1'b0);
				PH_ST6: pins(1'b1, 1'b1, 1'b1);
				PH_ST7: pins(1'b0, 1'b1, 1'b1);
				default: pins(1'b0, 1'b0, 1'b0);
			endcase
			len = is_long ? long_len : short_len;
			delay = (len == '0) ? '0 : len - BYTE_W'(1);
		endfunction

		function void wrap_up();
			phase = PH_IDLE;
			delay = '0;
			pins(1'b0, 1'b0, 1'b0);
		endfunction

		function void take_tick(item_t it);
			logic done;
			status_t s;
			done = 1'b0;
			if (phase == PH_IDLE) begin
				if (it.cmd inside {[ACT_RESET:ACT_READ]}) begin
					bit_cnt = '0;
					case (it.cmd)
						ACT_RESET: enter(PH_CPRE);
						ACT_START: enter(PH_ST1);
						ACT_WRITE: begin
							shreg = it.tx_byte;
							enter(PH_WSET);
						end
						default: begin
							shreg = '0;
							end_level = it.end_read;
							enter(PH_RREL);
						end
					endcase
				end
			end else if (delay != '0) begin
				delay = delay - BYTE_W'(1);
			end else begin
				case (phase)
					PH_WSET: enter(PH_WHIGH);
					PH_WHIGH: begin
						shreg = {shreg[6:0], 1'b0};
						enter(PH_WLOW);
					end
					PH_WLOW: begin
						bit_cnt = bit_cnt + 4'd1;
						enter(bit_cnt < 4'd8 ? PH_WSET : PH_WACKH);
					end
					PH_WACKH: begin
						ack = it.data_line;
						enter(PH_WACKS);
					end
					PH_RREL: enter(PH_RHIGH);
					PH_RHIGH: begin
						shreg = {shreg[6:0], it.data_line};
						enter(PH_RLOW);
					end
					PH_RLOW: begin
						bit_cnt = bit_cnt + 4'd1;
						enter(bit_cnt < 4'd8 ? PH_RHIGH : PH_RACK);
					end
					PH_RACK: enter(PH_RTAIL);
					PH_RTAIL: begin
						last_rx = shreg;
						wrap_up();
						done = 1'b1;
					end
					PH_CPRE: enter(PH_CHIGH);
					PH_CHIGH: enter(PH_CLOW);
					PH_CLOW: begin
						bit_cnt = bit_cnt + 4'd1;
						enter(bit_cnt < 4'd9 ? PH_CHIGH : PH_ST1);
					end
					PH_ST1: enter(PH_ST2);
					PH_ST2: enter(PH_ST3);
					PH_ST3: enter(PH_ST4);
					PH_ST4: enter(PH_ST5);
					PH_ST5: enter(PH_ST6);
					PH_ST6: enter(PH_ST7);
					default: begin
						wrap_up();
						done = 1'b1;
					end
				endcase
			end
			s.sck = pin_sck;
			s.data_drive = pin_drive;
			s.data_level = pin_level;
			s.busy_res = (phase != PH_IDLE);
			s.op_done = done;
			s.rx_byte = last_rx;
			s.ack_error = ack;
			s.conversion_ready = ~it.data_line;
			due_status.push_back(s);
		endfunction

		function void note_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t %s expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_status(status_t got);
			status_t want;
			if (due_status.size() == 0) begin
				errors++;
				$display("%0t status transfer expected none actual %0h", $time, got);
			end else begin
				want = due_status.pop_front();
				note_field("sck", want.sck, got.sck);
				note_field("data_drive", want.data_drive, got.data_drive);
				note_field("data_level", want.data_level, got.data_level);
				note_field("busy_res", want.busy_res, got.busy_res);
				note_field("op_done", want.op_done, got.op_done);
				note_field("rx_byte", want.rx_byte, got.rx_byte);
				note_field("ack_error", want.ack_error, got.ack_error);
				note_field("conversion_ready", want.conversion_ready, got.conversion_ready);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0] cfg_wdata;
	int cycle_count = 0;
	int items_sent = 0;
	bit tx_quiet = 1'b0;
	int tx_stretch = 0;
	bit rx_quiet = 1'b0;
	int rx_stretch = 0;
	bus_timeline book = new();

	tsbm_tick_if tick_bus();
	tsbm_status_if status_bus();

	two_wire_sensor_bus_master u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.tick(tick_bus),
		.status(status_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_tick(input item_t it);
		int gap;
		if (tx_stretch == 0) begin
			tx_quiet = ($urandom_range(0, 2) == 0);
			tx_stretch = $urandom_range(20, 300);
		end
		tx_stretch--;
		gap = tx_quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			tick_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_bus.valid <= 1'b1;
		tick_bus.action <= it.cmd;
		tick_bus.tx_byte <= it.tx_byte;
		tick_bus.end_read <= it.end_read;
		tick_bus.data_line <= it.data_line;
		@(posedge clk);
		while (!tick_bus.ready) @(posedge clk);
		book.take_tick(it);
		items_sent++;
	endtask

	task automatic settle();
		tick_bus.valid <= 1'b0;
		while (book.due_status.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_lengths(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] l);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_SHORT;
		cfg_wdata <= s;
		@(posedge clk);
		book.set_reg(REG_SHORT, s);
		cfg_index <= REG_LONG;
		cfg_wdata <= l;
		@(posedge clk);
		book.set_reg(REG_LONG, l);
		cfg_we <= 1'b0;
	endtask

	task automatic filler_tick(input logic [ACT_W-1:0] act);
		item_t it;
		it.cmd = act;
		it.tx_byte = $urandom;
		it.end_read = $urandom;
		it.data_line = $urandom;
		send_tick(it);
	endtask

	// A negative line_mode leaves the data line random, otherwise it is held at that level.
	task automatic run_cmd(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] tx,
		input logic endr, input int line_mode, input bit noisy);
		item_t it;
		it.cmd = act;
		it.tx_byte = tx;
		it.end_read = endr;
		it.data_line = (line_mode < 0) ? 1'($urandom) : line_mode[0];
		send_tick(it);
		while (book.phase != PH_IDLE) begin
			it.cmd = (noisy && $urandom_range(0, 7) == 0) ?
				3'($urandom_range(ACT_RESET, ACT_LAST_CODE)) : ACT_TICK;
			it.tx_byte = $urandom;
			it.end_read = $urandom;
			it.data_line = (line_mode < 0) ? 1'($urandom) : line_mode[0];
			send_tick(it);
		end
	endtask

	initial begin
		status_t got;
		int stall;
		status_bus.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (rx_stretch == 0) begin
				rx_quiet = ($urandom_range(0, 2) == 0);
				rx_stretch = $urandom_range(20, 300);
			end
			rx_stretch--;
			stall = rx_quiet ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				status_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			status_bus.ready <= 1'b1;
			@(posedge clk);
			while (!status_bus.valid) @(posedge clk);
			got.sck = status_bus.sck;
			got.data_drive = status_bus.data_drive;
			got.data_level = status_bus.data_level;
			got.busy_res = status_bus.busy_res;
			got.op_done = status_bus.op_done;
			got.rx_byte = status_bus.rx_byte;
			got.ack_error = status_bus.ack_error;
			got.conversion_ready = status_bus.conversion_ready;
			book.check_status(got);
		end
	end

	initial begin
		int n;
		int line_mode;
		cfg_we <= 1'b0;
		cfg_index <= REG_SHORT;
		cfg_wdata <= '0;
		tick_bus.valid <= 1'b0;
		tick_bus.action <= ACT_TICK;
		tick_bus.tx_byte <= '0;
		tick_bus.end_read <= 1'b0;
		tick_bus.data_line <= 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		filler_tick(ACT_TICK);
		filler_tick(ACT_READ + 3'd1);
		filler_tick(ACT_LAST_CODE - 3'd1);
		filler_tick(ACT_LAST_CODE);
		run_cmd(ACT_START, 8'h00, 1'b0, -1, 1'b0);
		set_lengths(8'd1, 8'd1);
		run_cmd(ACT_RESET, 8'h00, 1'b0, -1, 1'b0);
		run_cmd(ACT_START, 8'hff, 1'b1, -1, 1'b0);
		run_cmd(ACT_WRITE, 8'h00, 1'b0, 0, 1'b0);
		run_cmd(ACT_WRITE, 8'hff, 1'b1, 1, 1'b0);
		run_cmd(ACT_READ, 8'h3c, 1'b0, -1, 1'b0);
		run_cmd(ACT_READ, 8'h00, 1'b1, 1, 1'b0);
		run_cmd(ACT_READ, 8'hff, 1'b0, 0, 1'b0);
		run_cmd(ACT_WRITE, 8'ha5, 1'b0, -1, 1'b1);
		set_lengths(8'd0, 8'd0);
		run_cmd(ACT_WRITE, 8'h5a, 1'b1, -1, 1'b0);
		run_cmd(ACT_READ, 8'h00, 1'b1, -1, 1'b1);
		set_lengths(8'd2, 8'd1);
		run_cmd(ACT_START, 8'h81, 1'b0, -1, 1'b0);
		set_lengths(8'd1, 8'd3);
		run_cmd(ACT_WRITE, 8'h7e, 1'b0, -1, 1'b0);
		set_lengths(8'd3, 8'd2);
		run_cmd(ACT_RESET, 8'h00, 1'b0, -1, 1'b1);

		n = 0;
		while (items_sent < ITEM_TARGET) begin
			if (n % 4 == 0) begin
				set_lengths(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
			end else if ($urandom_range(0, 9) == 0) begin
				settle();
			end
			repeat ($urandom_range(0, 2)) begin
				filler_tick(($urandom_range(0, 1) == 0) ? ACT_TICK :
					3'($urandom_range(ACT_READ + 1, ACT_LAST_CODE)));
			end
			line_mode = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : -1;
			run_cmd(3'($urandom_range(ACT_RESET, ACT_READ)), 8'($urandom), 1'($urandom),
				line_mode, $urandom_range(0, 3) == 0);
			n++;
		end

		settle();
		if (book.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

// File: sim.f
sv/tsbm_pkg.sv
sv/tsbm_tick_if.sv
sv/tsbm_status_if.sv
sv/tsbm_front.sv
sv/tsbm_queue.sv
sv/tsbm_back.sv
sv/two_wire_sensor_bus_master.sv
tb/sv/tb.sv
